// ===== sv/cvwm_pkg.sv =====
// Package for the 2-D valid-window multiply-accumulate core.
// Holds field widths, register indexes, command codes and shared types.
// No dependencies.
package cvwm_pkg;

    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 4096;

    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int RES_W      = 32;
    localparam int IDX_W      = 5;
    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int KS_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 3'd4;

    localparam logic [IW_W-1:0] IW_RESET = 11'd1024;
    localparam logic [IH_W-1:0] IH_RESET = 13'd1024;
    localparam logic [KS_W-1:0] KS_RESET = 3'd3;

    localparam logic CMD_COEF  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Output queue that decouples the result side from the input side.
    localparam int OUT_PTR_W = 3;
    localparam int OUT_DEPTH = 1 << OUT_PTR_W;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [RES_W-1:0]  res_t;

    function automatic logic [IH_W-1:0] clamp_height(input logic [IH_W-1:0] v);
        logic [IH_W-1:0] r;
        if (v == '0) begin
            r = IH_W'(1);
        end
        else if (v > IH_W'(MAX_HEIGHT)) begin
            r = IH_W'(MAX_HEIGHT);
        end
        else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== sv/conv2d_valid_window_mac_core.sv =====
// Top level of the 2-D valid-window multiply-accumulate core.
// Depends on cvwm_pkg and on cvwm_ram for the line store.
//
// The core takes one word per clock while in_stall is low, coefficient writes and
// raster-order pixels alike. A pixel whose window lies inside the frame passes its
// result through the product, row-sum and total registers; the window multiplies all
// taps in parallel and a registered adder tree sums them. The line store is one memory
// that is read when a pixel is accepted and written back in the next cycle, so a pixel
// at the same column in the next cycle (a one-pixel-wide image) is served by forwarding.
// An eight-word output queue lets the input run on while results wait; in_stall rises
// once eight results are in flight or queued. No clearing pass follows reset: a fill
// count marks which columns of the line store hold data, and the others read as zero.
module conv2d_valid_window_mac_core #(
    parameter int MAX_KERNEL = cvwm_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = cvwm_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [cvwm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cvwm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic [cvwm_pkg::IDX_W-1:0]           coef_index,
    input  logic signed [cvwm_pkg::COEF_W-1:0]   coefficient,
    input  logic signed [cvwm_pkg::PIX_W-1:0]    pixel,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [cvwm_pkg::RES_W-1:0]    result,
    output logic                                 frame_last
);

    import cvwm_pkg::*;

    localparam int MK      = MAX_KERNEL;
    localparam int NTAP    = MK * MK;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int KD_W    = $clog2(MK + 1);
    localparam int KI_W    = (NTAP > 1) ? $clog2(NTAP) : 1;
    localparam int LINES   = (MK > 1) ? MK - 1 : 1;
    localparam int LINE_DW = LINES * PIX_W;
    localparam int PROD_W  = PIX_W + COEF_W;
    localparam int RSUM_W  = PROD_W + $clog2(MK + 1);
    localparam int ACC_W   = PROD_W + $clog2(NTAP + 2) + 1;
    localparam int PEND_W  = $clog2(OUT_DEPTH + 1);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // Configuration registers.
    logic [IW_W-1:0]  iw_reg;
    logic [IH_W-1:0]  ih_reg;
    logic [KS_W-1:0]  kh_reg;
    logic [KS_W-1:0]  kw_reg;
    res_t             bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg   <= IW_RESET;
            ih_reg   <= IH_RESET;
            kh_reg   <= KS_RESET;
            kw_reg   <= KS_RESET;
            bias_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  iw_reg   <= cfg_data[IW_W-1:0];
                REG_IMAGE_HEIGHT: ih_reg   <= cfg_data[IH_W-1:0];
                REG_KERNEL_ROWS:  kh_reg   <= cfg_data[KS_W-1:0];
                REG_KERNEL_COLS:  kw_reg   <= cfg_data[KS_W-1:0];
                REG_BIAS:         bias_reg <= res_t'(cfg_data);
                default:          ;
            endcase
        end
    end

    // Register values limited to what the hardware supports.
    logic [IH_W-1:0]  w_wide;
    logic [WID_W-1:0] w_eff;
    logic [IH_W-1:0]  h_eff;
    logic [KS_W-1:0]  kh_c;
    logic [KS_W-1:0]  kw_c;
    logic [KD_W-1:0]  kh_eff;
    logic [KD_W-1:0]  kw_eff;
    logic [KD_W-1:0]  rshift;
    logic [KD_W-1:0]  cshift;

    always_comb
    begin
        if (iw_reg == '0)
        begin
            w_wide = IH_W'(1);
        end
        else if (IH_W'(iw_reg) > IH_W'(MAX_WIDTH))
        begin
            w_wide = IH_W'(MAX_WIDTH);
        end
        else
        begin
            w_wide = IH_W'(iw_reg);
        end
        w_eff = w_wide[WID_W-1:0];
        h_eff = clamp_height(ih_reg);

        kh_c = (kh_reg == '0) ? KS_W'(1) : ((kh_reg > KS_W'(MK)) ? KS_W'(MK) : kh_reg);
        kw_c = (kw_reg == '0) ? KS_W'(1) : ((kw_reg > KS_W'(MK)) ? KS_W'(MK) : kw_reg);
        kh_eff = kh_c[KD_W-1:0];
        kw_eff = kw_c[KD_W-1:0];
        rshift = KD_W'(MK) - kh_eff;
        cshift = KD_W'(MK) - kw_eff;
    end

    // Accept stage: position counters, emit decision and line store read.
    logic [COL_W-1:0]  col_cnt_reg;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [WID_W-1:0]  fill_reg;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;

    logic              acc_in;
    logic              acc_pix;
    logic              acc_coef;
    logic [WID_W-1:0]  c_inc;
    logic [IH_W-1:0]   r_inc;
    logic              col_wrap;
    logic              row_wrap;
    logic              emit;
    logic              at_last;
    logic              line_ok;
    logic              fwd;
    logic              pop;

    logic              s1_pix_reg;
    logic              s1_coef_reg;
    logic [COL_W-1:0]  s1_col_reg;

    assign in_stall = (pending_reg >= PEND_W'(OUT_DEPTH));
    assign acc_in   = in_valid && !in_stall;
    assign acc_pix  = acc_in && (command == CMD_PIXEL);
    assign acc_coef = acc_in && (command == CMD_COEF);

    assign c_inc    = WID_W'(col_cnt_reg) + WID_W'(1);
    assign r_inc    = IH_W'(row_cnt_reg) + IH_W'(1);
    assign col_wrap = (c_inc >= w_eff);
    assign row_wrap = (r_inc >= h_eff);
    assign emit     = (r_inc >= IH_W'(kh_eff)) && (c_inc >= WID_W'(kw_eff));
    assign at_last  = col_wrap && row_wrap;
    assign line_ok  = (WID_W'(col_cnt_reg) < fill_reg);
    // The previous pixel writes this column back in the current cycle.
    assign fwd      = s1_pix_reg && (s1_col_reg == col_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            fill_reg    <= '0;
        end
        else if (acc_pix)
        begin
            if (col_wrap)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_wrap ? '0 : r_inc[ROW_W-1:0];
            end
            else
            begin
                col_cnt_reg <= c_inc[COL_W-1:0];
            end
            if (c_inc > fill_reg)
            begin
                fill_reg <= c_inc;
            end
        end
    end

    // Stage one: line store data, window shift, kernel write.
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic              s1_fwd_reg;
    logic              s1_ok_reg;
    pix_t              s1_pixel_reg;
    logic [KI_W-1:0]   s1_cidx_reg;
    logic              s1_cok_reg;
    coef_t             s1_coef_val_reg;
    logic [IDX_W:0]    cidx_ext;

    assign cidx_ext = {1'b0, coef_index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pix_reg  <= 1'b0;
            s1_coef_reg <= 1'b0;
        end
        else
        begin
            s1_pix_reg  <= acc_pix;
            s1_coef_reg <= acc_coef;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg      <= col_cnt_reg;
        s1_emit_reg     <= emit;
        s1_last_reg     <= at_last;
        s1_fwd_reg      <= fwd;
        s1_ok_reg       <= line_ok;
        s1_pixel_reg    <= pixel;
        s1_cidx_reg     <= cidx_ext[KI_W-1:0];
        s1_cok_reg      <= (cidx_ext < (IDX_W + 1)'(NTAP));
        s1_coef_val_reg <= coefficient;
    end

    logic [LINE_DW-1:0] ram_rd;
    logic [LINE_DW-1:0] line_wr;
    logic [LINE_DW-1:0] last_wr_reg;
    pix_t               col_v [MK];

    always_comb
    begin
        for (int a = 0; a < MK - 1; a++)
        begin
            if (s1_fwd_reg)
            begin
                col_v[a] = pix_t'(last_wr_reg[a*PIX_W +: PIX_W]);
            end
            else if (s1_ok_reg)
            begin
                col_v[a] = pix_t'(ram_rd[a*PIX_W +: PIX_W]);
            end
            else
            begin
                col_v[a] = '0;
            end
        end
        col_v[MK-1] = s1_pixel_reg;
    end

    // Each line moves up one row when written back.
    for (genvar g = 0; g < LINES; g++)
    begin : g_line_wr
        assign line_wr[g*PIX_W +: PIX_W] = col_v[(g + 1) % MK];
    end

    always_ff @(posedge clk)
    begin
        if (s1_pix_reg)
        begin
            last_wr_reg <= line_wr;
        end
    end

    cvwm_ram #(
        .WIDTH (LINE_DW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_pix_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr),
        .rd_en   (acc_pix),
        .rd_addr (col_cnt_reg),
        .rd_data (ram_rd)
    );

    pix_t  win_reg  [MK][MK];
    coef_t kern_reg [NTAP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MK; i++)
            begin
                for (int j = 0; j < MK; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_pix_reg)
        begin
            for (int i = 0; i < MK; i++)
            begin
                for (int j = 0; j < MK - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][MK-1] <= col_v[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NTAP; k++)
            begin
                kern_reg[k] <= '0;
            end
        end
        else if (s1_coef_reg && s1_cok_reg)
        begin
            for (int k = 0; k < NTAP; k++)
            begin
                if (s1_cidx_reg == KI_W'(k))
                begin
                    kern_reg[k] <= s1_coef_val_reg;
                end
            end
        end
    end

    // Stage two: align the kernel to the bottom-right of the window and multiply.
    logic  v2_reg;
    logic  last2_reg;
    coef_t csel [MK][MK];
    logic signed [PROD_W-1:0] prod_reg [MK][MK];
    logic  v3_reg;
    logic  last3_reg;

    always_comb
    begin
        for (int i = 0; i < MK; i++)
        begin
            for (int j = 0; j < MK; j++)
            begin
                csel[i][j] = '0;
                for (int a = 0; a < MK; a++)
                begin
                    for (int b = 0; b < MK; b++)
                    begin
                        if ((int'(rshift) + a == i) && (int'(cshift) + b == j))
                        begin
                            csel[i][j] = kern_reg[a*MK + b];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MK; i++)
        begin
            for (int j = 0; j < MK; j++)
            begin
                prod_reg[i][j] <= PROD_W'(win_reg[i][j]) * PROD_W'(csel[i][j]);
            end
        end
    end

    // Stages three and four: row sums, then total with bias.
    logic signed [RSUM_W-1:0] rsum_reg [MK];
    logic signed [RSUM_W-1:0] rsum_c   [MK];
    logic signed [ACC_W-1:0]  sum_c;
    logic signed [ACC_W-1:0]  sum_reg;
    logic  v4_reg;
    logic  last4_reg;
    logic  v5_reg;
    logic  last5_reg;

    always_comb
    begin
        for (int i = 0; i < MK; i++)
        begin
            rsum_c[i] = '0;
            for (int j = 0; j < MK; j++)
            begin
                rsum_c[i] = rsum_c[i] + RSUM_W'(prod_reg[i][j]);
            end
        end
        sum_c = ACC_W'(bias_reg);
        for (int i = 0; i < MK; i++)
        begin
            sum_c = sum_c + ACC_W'(rsum_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MK; i++)
        begin
            rsum_reg[i] <= rsum_c[i];
        end
        sum_reg   <= sum_c;
        last2_reg <= s1_last_reg;
        last3_reg <= last2_reg;
        last4_reg <= last3_reg;
        last5_reg <= last4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= s1_pix_reg && s1_emit_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Saturation and the output queue.
    res_t sat;

    always_comb
    begin
        if (sum_reg > SAT_HI)
        begin
            sat = res_t'(SAT_HI[RES_W-1:0]);
        end
        else if (sum_reg < SAT_LO)
        begin
            sat = res_t'(SAT_LO[RES_W-1:0]);
        end
        else
        begin
            sat = res_t'(sum_reg[RES_W-1:0]);
        end
    end

    res_t                q_res_reg  [OUT_DEPTH];
    logic                q_last_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [PEND_W-1:0]    cnt_reg;
    logic [PEND_W-1:0]    cnt_next;

    assign out_valid  = (cnt_reg != '0);
    assign result     = q_res_reg[rd_ptr_reg];
    assign frame_last = q_last_reg[rd_ptr_reg];
    assign pop        = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (v5_reg)
        begin
            q_res_reg[wr_ptr_reg]  <= sat;
            q_last_reg[wr_ptr_reg] <= last5_reg;
        end
    end

    always_comb
    begin
        cnt_next     = cnt_reg + PEND_W'(v5_reg) - PEND_W'(pop);
        pending_next = pending_reg + PEND_W'(acc_pix && emit) - PEND_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (v5_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            cnt_reg     <= cnt_next;
            pending_reg <= pending_next;
        end
    end

    // Results in flight never exceed what the queue can take.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(OUT_DEPTH))
        else $error("more results in flight than the output queue holds");

    // Every queued word belongs to a pixel that is still counted.
    a_queue_le_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pending_reg)
        else $error("output queue holds more words than pixels pending");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (cnt_reg < PEND_W'(OUT_DEPTH)) || pop)
        else $error("output queue written while full");

    // Forwarded line data must come from a write-back in the previous cycle.
    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_pix_reg && s1_fwd_reg) |-> $past(s1_pix_reg))
        else $error("line store forwarding without a preceding write-back");

    // The column counter never runs past the filled part of the line store.
    a_fill_cover: assert property (@(posedge clk) disable iff (!rst_n)
        WID_W'(col_cnt_reg) <= fill_reg)
        else $error("column counter beyond the line store fill count");

endmodule

// ===== sv/cvwm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// A read of the address being written in the same cycle returns the old word.
// No dependencies.
module cvwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
